// ===== design/ndefenc_pkg.sv =====
// Package for the NDEF record encoder: item structs, register indexes,
// header flag constants and command codes. No dependencies.
package ndefenc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TNF        = 3'd0;
  localparam logic [2:0] REG_TYPE_LEN   = 3'd1;
  localparam logic [2:0] REG_PAYLOAD_LEN = 3'd2;
  localparam logic [2:0] REG_ID_LEN     = 3'd3;
  localparam logic [2:0] REG_FIRST      = 3'd4;
  localparam logic [2:0] REG_LAST       = 3'd5;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Input commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BODY  = 1'b1;

  // Flags byte bits
  localparam logic [7:0] FLAG_MB = 8'h80;
  localparam logic [7:0] FLAG_ME = 8'h40;
  localparam logic [7:0] FLAG_SR = 8'h10;
  localparam logic [7:0] FLAG_IL = 8'h08;
  localparam logic [15:0] SHORT_MAX = 16'h00FF;

  // Body byte count and total width: type + payload + id lengths
  localparam int CountW = 17;

  // Header bytes held back after the first one (at most six)
  localparam int HdrRestN = 6;
  localparam int HdrLeftW = 3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] body_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       surplus;
  } out_item_t;

endpackage

// ===== design/ndef_record_encoder_unit.sv =====
// NDEF record encoder: header generation and body pass-through with counting.
// Depends on ndefenc_pkg.
//
// An accepted item's first result byte is registered and presented in the next cycle.
// Throughput: one body item per cycle unless out_ready stalls; a start item yields
// three to seven header bytes, one per cycle unless stalled, and the input is held off
// while the header bytes after the first drain from the header shift register.
// Reset: synchronous active-low; clears config registers, count, total, header state and valid.
module ndef_record_encoder_unit
  import ndefenc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // Configuration registers
  logic [2:0]  tnf_r;
  logic [7:0]  type_len_r;
  logic [15:0] payload_len_r;
  logic [7:0]  id_len_r;
  logic        first_r;
  logic        last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tnf_r         <= '0;
      type_len_r    <= '0;
      payload_len_r <= '0;
      id_len_r      <= '0;
      first_r       <= 1'b0;
      last_r        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TNF:         tnf_r         <= cfg_wdata[2:0];
        REG_TYPE_LEN:    type_len_r    <= cfg_wdata[7:0];
        REG_PAYLOAD_LEN: payload_len_r <= cfg_wdata;
        REG_ID_LEN:      id_len_r      <= cfg_wdata[7:0];
        REG_FIRST:       first_r       <= cfg_wdata[0];
        REG_LAST:        last_r        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Record state and output register
  logic [CountW-1:0]       body_count_r, body_count_nxt;
  logic [CountW-1:0]       body_total_r, body_total_nxt;
  logic [8*HdrRestN-1:0]   hdr_r, hdr_nxt;
  logic [HdrLeftW-1:0]     hdr_left_r, hdr_left_nxt;
  logic                    hdr_empty_r, hdr_empty_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  // Header built from the current configuration
  logic                    short_rec;
  logic                    has_id;
  logic [7:0]              flags;
  logic [CountW-1:0]       total_cfg;
  logic [8*HdrRestN-1:0]   hdr_rest;
  logic [HdrLeftW-1:0]     hdr_rest_n;

  always_comb begin
    short_rec = (payload_len_r <= SHORT_MAX);
    has_id    = (id_len_r != 8'd0);
    flags     = {5'd0, tnf_r};
    if (first_r)   flags = flags | FLAG_MB;
    if (last_r)    flags = flags | FLAG_ME;
    if (short_rec) flags = flags | FLAG_SR;
    if (has_id)    flags = flags | FLAG_IL;
    total_cfg = {9'd0, type_len_r} + {1'b0, payload_len_r} + {9'd0, id_len_r};
    // byte i of the remaining header sits at bits [8i+7:8i]
    hdr_rest = '0;
    if (short_rec) begin
      hdr_rest[7:0]   = type_len_r;
      hdr_rest[15:8]  = payload_len_r[7:0];
      hdr_rest[23:16] = id_len_r;
      hdr_rest_n      = has_id ? HdrLeftW'(3) : HdrLeftW'(2);
    end else begin
      hdr_rest[7:0]   = type_len_r;
      hdr_rest[15:8]  = 8'd0;
      hdr_rest[23:16] = 8'd0;
      hdr_rest[31:24] = payload_len_r[15:8];
      hdr_rest[39:32] = payload_len_r[7:0];
      hdr_rest[47:40] = id_len_r;
      hdr_rest_n      = has_id ? HdrLeftW'(6) : HdrLeftW'(5);
    end
  end

  // Handshake: output register frees on take; header drain blocks input
  logic out_free;
  logic in_acc;
  logic [CountW-1:0] count_inc;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = out_free && (hdr_left_r == '0);
  assign in_acc    = in_valid && in_ready;
  assign count_inc = body_count_r + CountW'(1);

  // Next-state logic
  always_comb begin
    body_count_nxt = body_count_r;
    body_total_nxt = body_total_r;
    hdr_nxt        = hdr_r;
    hdr_left_nxt   = hdr_left_r;
    hdr_empty_nxt  = hdr_empty_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (hdr_left_r != '0) begin
      if (out_free) begin
        // next pending header byte
        out_valid_nxt          = 1'b1;
        out_data_nxt.out_byte  = hdr_r[7:0];
        out_data_nxt.last_byte = (hdr_left_r == HdrLeftW'(1)) && hdr_empty_r;
        out_data_nxt.surplus   = 1'b0;
        hdr_nxt                = hdr_r >> 8;
        hdr_left_nxt           = hdr_left_r - HdrLeftW'(1);
      end
    end else if (in_acc) begin
      out_valid_nxt = 1'b1;
      if (in_data.cmd == CMD_START) begin
        // emit flags now, queue the rest of the header
        out_data_nxt.out_byte  = flags;
        out_data_nxt.last_byte = 1'b0;
        out_data_nxt.surplus   = 1'b0;
        hdr_nxt        = hdr_rest;
        hdr_left_nxt   = hdr_rest_n;
        hdr_empty_nxt  = (total_cfg == '0);
        body_count_nxt = '0;
        body_total_nxt = total_cfg;
      end else if (body_count_r >= body_total_r) begin
        // beyond the declared lengths: echo, not counted
        out_data_nxt.out_byte  = in_data.body_byte;
        out_data_nxt.last_byte = 1'b0;
        out_data_nxt.surplus   = 1'b1;
      end else begin
        out_data_nxt.out_byte  = in_data.body_byte;
        out_data_nxt.last_byte = (count_inc == body_total_r);
        out_data_nxt.surplus   = 1'b0;
        body_count_nxt         = count_inc;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_count_r <= '0;
      body_total_r <= '0;
      hdr_left_r   <= '0;
      hdr_empty_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      body_count_r <= body_count_nxt;
      body_total_r <= body_total_nxt;
      hdr_left_r   <= hdr_left_nxt;
      hdr_empty_r  <= hdr_empty_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hdr_r      <= hdr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
